@@ rtl/tcpj_pkg.sv @@
// Shared widths, constants and controller/datapath handshake types for the
// trip chaining proximity join. No dependencies.
package tcpj_pkg;

    localparam int IdW      = 31;
    localparam int LonW     = 31;
    localparam int LatW     = 30;
    localparam int RadiusW  = 23;
    localparam int R2W      = 2 * RadiusW;
    localparam int DxW      = LonW;
    localparam int DyW      = LatW;
    localparam int SqxW     = 2 * DxW;
    localparam int SqyW     = 2 * DyW;
    localparam int SumW     = SqxW + 1;
    localparam int MatchW   = 6;

    localparam logic [MatchW-1:0]  MaxResults  = 6'd63;
    localparam logic [RadiusW-1:0] RadiusReset = 23'd251658;

    typedef struct packed {
        logic load;
        logic issue;
        logic flush;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic pipe_busy;
        logic pend_valid;
        logic out_free;
        logic match_full;
    } status_t;

endpackage

@@ rtl/tcpj_if.sv @@
// Valid/ready channels for trip beats in and matched pair beats out.
// Depends on tcpj_pkg for field widths.
interface tcpj_trip_if;
    logic                               valid;
    logic                               ready;
    logic                               new_set;
    logic        [tcpj_pkg::IdW-1:0]    trip_id;
    logic signed [tcpj_pkg::LonW-1:0]   start_lon;
    logic signed [tcpj_pkg::LatW-1:0]   start_lat;
    logic signed [tcpj_pkg::LonW-1:0]   end_lon;
    logic signed [tcpj_pkg::LatW-1:0]   end_lat;

    modport source (
        output valid, new_set, trip_id, start_lon, start_lat, end_lon, end_lat,
        input  ready
    );
    modport sink (
        input  valid, new_set, trip_id, start_lon, start_lat, end_lon, end_lat,
        output ready
    );
endinterface

interface tcpj_pair_if;
    logic                               valid;
    logic                               ready;
    logic        [tcpj_pkg::IdW-1:0]    earlier_id;
    logic signed [tcpj_pkg::LonW-1:0]   earlier_end_lon;
    logic signed [tcpj_pkg::LatW-1:0]   earlier_end_lat;
    logic        [tcpj_pkg::IdW-1:0]    later_id;
    logic signed [tcpj_pkg::LonW-1:0]   later_start_lon;
    logic signed [tcpj_pkg::LatW-1:0]   later_start_lat;
    logic                               last_match;

    modport source (
        output valid, earlier_id, earlier_end_lon, earlier_end_lat,
               later_id, later_start_lon, later_start_lat, last_match,
        input  ready
    );
    modport sink (
        input  valid, earlier_id, earlier_end_lon, earlier_end_lat,
               later_id, later_start_lon, later_start_lat, last_match,
        output ready
    );
endinterface

@@ rtl/tcpj_ctrl.sv @@
// Sequencer for one trip: accept, scan the stored ends, drain, flush, store.
// Depends on tcpj_pkg for the command and status types.
module tcpj_ctrl #(
    parameter int MAX_TRIPS = 64,
    parameter int CntW      = $clog2(MAX_TRIPS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [CntW-1:0]    count,
    input  tcpj_pkg::status_t  st,
    output logic               ready,
    output logic [CntW-1:0]    rd_idx,
    output tcpj_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FLUSH,
        S_STORE
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CntW-1:0] idx_reg;
    logic [CntW-1:0] idx_next;
    logic            more;

    assign more   = (idx_reg < count) && !st.match_full;
    assign ready  = (state_reg == S_IDLE);
    assign rd_idx = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.adv)
                begin
                    if (more)
                    begin
                        cmd.issue = 1'b1;
                        idx_next  = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!st.pipe_busy)
                begin
                    state_next = st.pend_valid ? S_FLUSH : S_STORE;
                end
            end
            S_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ rtl/tcpj_datapath.sv @@
// Trip store, distance pipeline, pending match and output register.
// Depends on tcpj_pkg and the pair channel interface.
module tcpj_datapath #(
    parameter int MAX_TRIPS = 64,
    parameter int CntW      = $clog2(MAX_TRIPS + 1),
    parameter int AddrW     = $clog2(MAX_TRIPS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcpj_pkg::cmd_t                      cmd,
    output tcpj_pkg::status_t                   st,
    input  logic [CntW-1:0]                     rd_idx,
    output logic [CntW-1:0]                     count,
    input  logic                                radius_we,
    input  logic [tcpj_pkg::RadiusW-1:0]        radius_wdata,
    input  logic                                new_set,
    input  logic        [tcpj_pkg::IdW-1:0]     trip_id,
    input  logic signed [tcpj_pkg::LonW-1:0]    start_lon,
    input  logic signed [tcpj_pkg::LatW-1:0]    start_lat,
    input  logic signed [tcpj_pkg::LonW-1:0]    end_lon,
    input  logic signed [tcpj_pkg::LatW-1:0]    end_lat,
    tcpj_pair_if.source                         pairs
);

    localparam int IdW  = tcpj_pkg::IdW;
    localparam int LonW = tcpj_pkg::LonW;
    localparam int LatW = tcpj_pkg::LatW;

    // configuration
    logic [tcpj_pkg::RadiusW-1:0] radius_reg;
    logic [tcpj_pkg::R2W-1:0]     r2_reg;

    // current trip
    logic        [IdW-1:0]  id_reg;
    logic signed [LonW-1:0] slon_reg;
    logic signed [LatW-1:0] slat_reg;
    logic signed [LonW-1:0] elon_reg;
    logic signed [LatW-1:0] elat_reg;
    logic [CntW-1:0]        count_reg;

    // store
    logic        [IdW-1:0]  mem_id  [MAX_TRIPS];
    logic signed [LonW-1:0] mem_lon [MAX_TRIPS];
    logic signed [LatW-1:0] mem_lat [MAX_TRIPS];

    // pipeline
    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic        [IdW-1:0]  id1_reg, id2_reg, id3_reg;
    logic signed [LonW-1:0] lon1_reg, lon2_reg, lon3_reg;
    logic signed [LatW-1:0] lat1_reg, lat2_reg, lat3_reg;
    logic [tcpj_pkg::DxW-1:0]  dx_reg;
    logic [tcpj_pkg::DyW-1:0]  dy_reg;
    logic [tcpj_pkg::SqxW-1:0] sqx_reg;
    logic [tcpj_pkg::SqyW-1:0] sqy_reg;

    logic [LonW:0]              dlon;
    logic [LatW:0]              dlat;
    logic [LonW:0]              mlon;
    logic [LatW:0]              mlat;
    logic [tcpj_pkg::SumW-1:0]  dist2;
    logic                       hit;

    // pending match and output
    logic                       pend_valid_reg;
    logic        [IdW-1:0]      pend_id_reg;
    logic signed [LonW-1:0]     pend_lon_reg;
    logic signed [LatW-1:0]     pend_lat_reg;
    logic [tcpj_pkg::MatchW-1:0] match_cnt_reg;
    logic                       match_full;

    logic                       out_valid_reg;
    logic                       out_free;
    logic                       out_load;
    logic        [IdW-1:0]      o_eid_reg;
    logic signed [LonW-1:0]     o_elon_reg;
    logic signed [LatW-1:0]     o_elat_reg;
    logic        [IdW-1:0]      o_lid_reg;
    logic signed [LonW-1:0]     o_slon_reg;
    logic signed [LatW-1:0]     o_slat_reg;
    logic                       o_last_reg;

    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= tcpj_pkg::RadiusReset;
        end
        else if (radius_we)
        begin
            radius_reg <= radius_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= tcpj_pkg::R2W'(radius_reg) * tcpj_pkg::R2W'(radius_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg   <= trip_id;
            slon_reg <= start_lon;
            slat_reg <= start_lat;
            elon_reg <= end_lon;
            elat_reg <= end_lat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load && new_set)
        begin
            count_reg <= '0;
        end
        else if (cmd.store && (count_reg < CntW'(MAX_TRIPS)))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_reg < CntW'(MAX_TRIPS)))
        begin
            mem_id[count_reg[AddrW-1:0]]  <= id_reg;
            mem_lon[count_reg[AddrW-1:0]] <= elon_reg;
            mem_lat[count_reg[AddrW-1:0]] <= elat_reg;
        end
        if (cmd.issue)
        begin
            id1_reg  <= mem_id[rd_idx[AddrW-1:0]];
            lon1_reg <= mem_lon[rd_idx[AddrW-1:0]];
            lat1_reg <= mem_lat[rd_idx[AddrW-1:0]];
        end
    end

    assign dlon  = $signed({lon1_reg[LonW-1], lon1_reg}) - $signed({slon_reg[LonW-1], slon_reg});
    assign dlat  = $signed({lat1_reg[LatW-1], lat1_reg}) - $signed({slat_reg[LatW-1], slat_reg});
    assign mlon  = dlon[LonW] ? ((LonW+1)'(0) - dlon) : dlon;
    assign mlat  = dlat[LatW] ? ((LatW+1)'(0) - dlat) : dlat;
    assign dist2 = tcpj_pkg::SumW'(sqx_reg) + tcpj_pkg::SumW'(sqy_reg);
    assign match_full = (match_cnt_reg == tcpj_pkg::MaxResults);
    assign hit   = v3_reg && (dist2 < tcpj_pkg::SumW'(r2_reg)) && !match_full;
    assign out_free = !out_valid_reg || pairs.ready;
    assign adv   = !(hit && pend_valid_reg && !out_free);
    assign out_load = (hit && pend_valid_reg && adv) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg   <= mlon[tcpj_pkg::DxW-1:0];
            dy_reg   <= mlat[tcpj_pkg::DyW-1:0];
            id2_reg  <= id1_reg;
            lon2_reg <= lon1_reg;
            lat2_reg <= lat1_reg;
            sqx_reg  <= tcpj_pkg::SqxW'(dx_reg) * tcpj_pkg::SqxW'(dx_reg);
            sqy_reg  <= tcpj_pkg::SqyW'(dy_reg) * tcpj_pkg::SqyW'(dy_reg);
            id3_reg  <= id2_reg;
            lon3_reg <= lon2_reg;
            lat3_reg <= lat2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            match_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                match_cnt_reg <= '0;
            end
            else if (hit && adv)
            begin
                match_cnt_reg <= match_cnt_reg + 1'b1;
            end

            if (hit && adv)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pairs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && adv)
        begin
            pend_id_reg  <= id3_reg;
            pend_lon_reg <= lon3_reg;
            pend_lat_reg <= lat3_reg;
        end
        if (out_load)
        begin
            o_eid_reg  <= pend_id_reg;
            o_elon_reg <= pend_lon_reg;
            o_elat_reg <= pend_lat_reg;
            o_lid_reg  <= id_reg;
            o_slon_reg <= slon_reg;
            o_slat_reg <= slat_reg;
            o_last_reg <= cmd.flush;
        end
    end

    assign pairs.valid           = out_valid_reg;
    assign pairs.earlier_id      = o_eid_reg;
    assign pairs.earlier_end_lon = o_elon_reg;
    assign pairs.earlier_end_lat = o_elat_reg;
    assign pairs.later_id        = o_lid_reg;
    assign pairs.later_start_lon = o_slon_reg;
    assign pairs.later_start_lat = o_slat_reg;
    assign pairs.last_match      = o_last_reg;

    assign st.adv        = adv;
    assign st.pipe_busy  = v1_reg || v2_reg || v3_reg;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;
    assign st.match_full = match_full;

endmodule

@@ rtl/trip_chain_proximity_join.sv @@
// Top level of the trip chaining proximity join: controller plus datapath.
// Depends on tcpj_pkg, tcpj_if, tcpj_ctrl and tcpj_datapath.
// Trips are taken one at a time: a new trip is accepted only after the previous one is stored.
// The stored ends are read one per cycle while the pipeline is not stalled by the output.
// Each matched earlier trip is kept pending; hold each pair until the
// next match or the end of the scan. Reset: radius returns to 251658, the store empties.
module trip_chain_proximity_join #(
    parameter int MAX_TRIPS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           radius_we,
    input  logic [tcpj_pkg::RadiusW-1:0]   radius_wdata,
    tcpj_trip_if.sink                      trips,
    tcpj_pair_if.source                    pairs
);

    localparam int CntW  = $clog2(MAX_TRIPS + 1);
    localparam int AddrW = $clog2(MAX_TRIPS);

    tcpj_pkg::cmd_t    cmd;
    tcpj_pkg::status_t st;
    logic [CntW-1:0]   rd_idx;
    logic [CntW-1:0]   count;
    logic              ctl_ready;
    logic              accept;

    assign trips.ready = ctl_ready;
    assign accept      = trips.valid && ctl_ready;

    tcpj_ctrl #(
        .MAX_TRIPS (MAX_TRIPS),
        .CntW      (CntW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .count  (count),
        .st     (st),
        .ready  (ctl_ready),
        .rd_idx (rd_idx),
        .cmd    (cmd)
    );

    tcpj_datapath #(
        .MAX_TRIPS (MAX_TRIPS),
        .CntW      (CntW),
        .AddrW     (AddrW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .rd_idx       (rd_idx),
        .count        (count),
        .radius_we    (radius_we),
        .radius_wdata (radius_wdata),
        .new_set      (trips.new_set),
        .trip_id      (trips.trip_id),
        .start_lon    (trips.start_lon),
        .start_lat    (trips.start_lat),
        .end_lon      (trips.end_lon),
        .end_lat      (trips.end_lat),
        .pairs        (pairs)
    );

endmodule
